// ===== rtl/llrf_pkg.sv =====
package llrf_pkg;

    localparam int MAX_ROWS_DEF    = 256;
    localparam int MAX_COLS_DEF    = 256;
    localparam int STACK_DEPTH_DEF = 4096;
    localparam int SEED_DEPTH_DEF  = 256;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 9;
    localparam int LEVEL_W  = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_LEVEL = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIRST = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_NEXT  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_END   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_FILL  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ADJ  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_LEVEL = 2'd2;

endpackage

// ===== rtl/llrf_ram.sv =====
module llrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/level_line_region_fill_core.sv =====
// level line region fill core
// input requests arrive on s_tvalid/s_tready: s_tuser carries the command code,
// s_tdata the point position, the level and the closed flag. each accepted
// request gives exactly one result on m_tvalid/m_tready (status and pixel).
// configuration (image size, background level) is written on cfg_valid/cfg_ready,
// always ready; the user must write it only while no request is in work, which
// the core does not enforce. one request is in work at a time; s_tready is high
// only when the sequencer is idle. clear image and start level sweep the image
// or both edge memories, one entry a cycle. the length of a fill grows with the
// probed pixels and the stack pushes and pops, since the image memory has a
// single read port.
// after reset both edge memories are cleared by a pass over all MAX_ROWS*MAX_COLS
// entries during which no request is taken; config writes are taken as usual.
// the image memory holds no defined value until a clear image request.
// a finished result waits in the output register while the receiver stalls;
// the next request is still taken, its result waits until the register frees.
module level_line_region_fill_core #(
    parameter int MAX_ROWS    = llrf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS    = llrf_pkg::MAX_COLS_DEF,
    parameter int STACK_DEPTH = llrf_pkg::STACK_DEPTH_DEF,
    parameter int SEED_DEPTH  = llrf_pkg::SEED_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pos_col, pos_row, level, closed, zero pad
    input  logic [2:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, pixel, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [llrf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [llrf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NPIX = MAX_ROWS * MAX_COLS;
    localparam int AW   = $clog2(NPIX);
    localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int MAXP = (MAXD > 512) ? MAXD : 512;
    localparam int CW   = $clog2(MAXP + 2) + 1;
    localparam int YW   = $clog2(MAX_ROWS);
    localparam int XW   = $clog2(MAX_COLS);
    localparam int SW   = YW + 2 * XW + 1;
    localparam int SPW  = $clog2(STACK_DEPTH + 1);
    localparam int STAW = $clog2(STACK_DEPTH);
    localparam int SRW  = $clog2(MAX_ROWS + 1);
    localparam int SCW  = $clog2(MAX_COLS + 1);
    localparam int SDW  = SRW + SCW;
    localparam int SCNW = $clog2(SEED_DEPTH + 1);
    localparam int SAW  = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
    localparam int PW   = llrf_pkg::POS_W;
    localparam int LW   = llrf_pkg::LEVEL_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_EXEC  = 5'd1;
    localparam logic [4:0] S_ICLR  = 5'd2;
    localparam logic [4:0] S_ECLR  = 5'd3;
    localparam logic [4:0] S_TOG   = 5'd4;
    localparam logic [4:0] S_PRD   = 5'd5;
    localparam logic [4:0] S_RESP  = 5'd6;
    localparam logic [4:0] S_SEED  = 5'd7;
    localparam logic [4:0] S_F0    = 5'd8;
    localparam logic [4:0] S_L1    = 5'd9;
    localparam logic [4:0] S_R1    = 5'd10;
    localparam logic [4:0] S_R1B   = 5'd11;
    localparam logic [4:0] S_PUSH  = 5'd12;
    localparam logic [4:0] S_POP   = 5'd13;
    localparam logic [4:0] S_V     = 5'd14;
    localparam logic [4:0] S_HL    = 5'd15;
    localparam logic [4:0] S_EA    = 5'd16;
    localparam logic [4:0] S_MAIN  = 5'd17;
    localparam logic [4:0] S_HR    = 5'd18;
    localparam logic [4:0] S_HRB   = 5'd19;
    localparam logic [4:0] S_AFTER = 5'd20;

    typedef logic signed [CW-1:0] coord_t;

    function automatic coord_t ext(input logic [PW-1:0] v);
        ext = signed'(CW'(v));
    endfunction

    function automatic logic [AW-1:0] pix_addr(input coord_t r, input coord_t c);
        pix_addr = AW'(AW'(unsigned'(r)) * AW'(MAX_COLS) + AW'(unsigned'(c)));
    endfunction

    // registers
    logic [4:0]  state_reg, state_next;
    logic        ph_reg, ph_next;
    logic        init_reg, init_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] num_rows_reg, num_cols_reg;
    logic [LW-1:0] bg_reg;
    logic [2:0]  func_reg;
    logic [PW-1:0] col_reg, row_reg;
    logic [LW-1:0] level_reg;
    logic        closed_reg;
    logic [LW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [PW-1:0] first_r_reg, first_r_next, first_c_reg, first_c_next;
    logic [PW-1:0] last_r_reg, last_r_next, last_c_reg, last_c_next;
    logic [1:0]  line_reg, line_next;
    logic [SCNW-1:0] seed_cnt_reg, seed_cnt_next, si_reg, si_next;
    logic [SPW-1:0] sp_reg, sp_next;
    coord_t y_reg, y_next, x_reg, x_next, x1_reg, x1_next, x2_reg, x2_next;
    coord_t left_reg, left_next, right_reg, right_next;
    logic   dn_reg, dn_next;
    coord_t push_y_reg, push_y_next, push_xl_reg, push_xl_next;
    coord_t push_xr_reg, push_xr_next;
    logic   push_dn_reg, push_dn_next;
    logic [4:0] ret_reg, ret_next;
    coord_t tog_r_reg, tog_r_next, tog_c_reg, tog_c_next;
    logic   tog_vert_reg, tog_vert_next;
    logic   ovf_reg, ovf_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [LW-1:0] res_pixel_reg, res_pixel_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [LW-1:0] out_pixel_reg, out_pixel_next;

    // memory ports
    logic          img_we, edge_v_we, edge_h_we, stk_we, seed_we;
    logic [AW-1:0] img_waddr, img_raddr, edge_waddr, v_raddr, h_raddr;
    logic [LW-1:0] img_wdata, img_q;
    logic          edge_wdata_v, edge_wdata_h, v_q, h_q;
    logic [SW-1:0] stk_wdata, stk_q;
    logic [SPW-1:0] sp_m1;
    logic [SDW-1:0] seed_wdata, seed_q;

    // probe
    coord_t dim_r, dim_c, pv_y, pv_x, vc, hr;
    logic   in_img, v_ok, h_ok, vbit, hbit, fillable, can_h, can_v;

    // point handling
    coord_t pt_r, pt_c, tgt_r, tgt_c, lr, lc, dl, dc, tr, tc, sr, sc, push_tgt;
    logic   adj, tvert, tvalid, svalid, pt_out, rd_out;
    coord_t sd_r, sd_c;

    llrf_ram #(.WIDTH(LW), .DEPTH(NPIX)) u_img (
        .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
        .raddr(img_raddr), .rdata(img_q)
    );

    llrf_ram #(.WIDTH(1), .DEPTH(NPIX)) u_vedge (
        .clk(clk), .we(edge_v_we), .waddr(edge_waddr), .wdata(edge_wdata_v),
        .raddr(v_raddr), .rdata(v_q)
    );

    llrf_ram #(.WIDTH(1), .DEPTH(NPIX)) u_hedge (
        .clk(clk), .we(edge_h_we), .waddr(edge_waddr), .wdata(edge_wdata_h),
        .raddr(h_raddr), .rdata(h_q)
    );

    llrf_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(sp_reg[STAW-1:0]), .wdata(stk_wdata),
        .raddr(sp_m1[STAW-1:0]), .rdata(stk_q)
    );

    llrf_ram #(.WIDTH(SDW), .DEPTH(SEED_DEPTH)) u_seed (
        .clk(clk), .we(seed_we), .waddr(seed_cnt_reg[SAW-1:0]), .wdata(seed_wdata),
        .raddr(si_reg[SAW-1:0]), .rdata(seed_q)
    );

    assign sp_m1 = sp_reg - 1'b1;

    // image size with saturation
    always_comb
    begin
        dim_r = ext(num_rows_reg);
        dim_c = ext(num_cols_reg);
        if (dim_r < 1)
        begin
            dim_r = 1;
        end
        if (dim_r > MAX_ROWS)
        begin
            dim_r = CW'(MAX_ROWS);
        end
        if (dim_c < 1)
        begin
            dim_c = 1;
        end
        if (dim_c > MAX_COLS)
        begin
            dim_c = CW'(MAX_COLS);
        end
    end

    // probe address and tests
    always_comb
    begin
        pv_y = y_reg;
        pv_x = x_reg;
        case (state_reg)
            S_L1, S_V:
            begin
                pv_x = x1_reg;
            end
            S_R1:
            begin
                pv_x = x2_reg;
            end
            S_PRD:
            begin
                pv_y = ext(row_reg);
                pv_x = ext(col_reg);
            end
            S_TOG:
            begin
                pv_y = tog_r_reg;
                pv_x = tog_c_reg;
            end
            default:
            begin
            end
        endcase
        vc = (state_reg == S_R1 || state_reg == S_HR) ? pv_x - 1 : pv_x;
        hr = ((state_reg == S_V || state_reg == S_EA) && dn_reg) ? pv_y - 1 : pv_y;
        in_img   = pv_y >= 0 && pv_y < dim_r && pv_x >= 0 && pv_x < dim_c;
        v_ok     = pv_y >= 0 && pv_y < dim_r && vc >= 0 && vc < dim_c - 1;
        h_ok     = hr >= 0 && hr < dim_r - 1 && pv_x >= 0 && pv_x < dim_c;
        vbit     = v_ok && v_q;
        hbit     = h_ok && h_q;
        fillable = img_q != cur_reg && img_q == prev_reg;
        can_h    = in_img && !vbit && fillable;
        can_v    = in_img && !hbit && fillable;
    end

    // point step, edge to toggle and seed
    always_comb
    begin
        pt_r  = ext(row_reg);
        pt_c  = ext(col_reg);
        lr    = ext(last_r_reg);
        lc    = ext(last_c_reg);
        tgt_r = (func_reg == llrf_pkg::FUNC_END) ? ext(first_r_reg) : pt_r;
        tgt_c = (func_reg == llrf_pkg::FUNC_END) ? ext(first_c_reg) : pt_c;
        dl    = tgt_r - lr;
        dc    = tgt_c - lc;
        adj   = ((dl == 1 || dl == -1) && dc == 0) || (dl == 0 && (dc == 1 || dc == -1));
        if (dl == 1)
        begin
            tvert = 1'b1;
            tr    = lr;
            tc    = lc - 1;
        end
        else if (dl == -1)
        begin
            tvert = 1'b1;
            tr    = lr - 1;
            tc    = lc - 1;
        end
        else if (dc == 1)
        begin
            tvert = 1'b0;
            tr    = lr - 1;
            tc    = lc;
        end
        else
        begin
            tvert = 1'b0;
            tr    = lr - 1;
            tc    = lc - 1;
        end
        if (tvert)
        begin
            tvalid = tr >= 0 && tr < dim_r && tc >= 0 && tc < dim_c - 1;
        end
        else
        begin
            tvalid = tr >= 0 && tr < dim_r - 1 && tc >= 0 && tc < dim_c;
        end
        if (dl == 0)
        begin
            sr = (dc == 1) ? lr - 1 : lr;
            sc = (dc == 1) ? lc : lc - 1;
        end
        else
        begin
            sr = (dl == 1) ? lr : lr - 1;
            sc = (dl == 1) ? lc : lc - 1;
        end
        svalid     = sr >= 0 && sc >= 0 && seed_cnt_reg < SEED_DEPTH;
        seed_wdata = {SCW'(sc), SRW'(sr)};
        pt_out     = pt_c > dim_c || pt_r > dim_r;
        rd_out     = pt_c >= dim_c || pt_r >= dim_r;
        sd_r       = signed'(CW'(seed_q[SRW-1:0]));
        sd_c       = signed'(CW'(seed_q[SDW-1:SRW]));
        push_tgt   = push_dn_reg ? push_y_reg + 1 : push_y_reg - 1;
        stk_wdata  = {push_dn_reg, XW'(push_xr_reg), XW'(push_xl_reg), YW'(push_y_reg)};
    end

    assign img_raddr    = pix_addr(pv_y, pv_x);
    assign v_raddr      = pix_addr(pv_y, vc);
    assign h_raddr      = pix_addr(hr, pv_x);
    assign img_waddr    = (state_reg == S_ICLR) ? cnt_reg : img_raddr;
    assign img_wdata    = (state_reg == S_ICLR) ? bg_reg : cur_reg;
    assign edge_waddr   = (state_reg == S_ECLR) ? cnt_reg : img_raddr;
    assign edge_wdata_v = (state_reg == S_ECLR) ? 1'b0 : !v_q;
    assign edge_wdata_h = (state_reg == S_ECLR) ? 1'b0 : !h_q;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        ph_next         = ph_reg;
        init_next       = init_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        first_r_next    = first_r_reg;
        first_c_next    = first_c_reg;
        last_r_next     = last_r_reg;
        last_c_next     = last_c_reg;
        line_next       = line_reg;
        seed_cnt_next   = seed_cnt_reg;
        si_next         = si_reg;
        sp_next         = sp_reg;
        y_next          = y_reg;
        x_next          = x_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        dn_next         = dn_reg;
        push_y_next     = push_y_reg;
        push_xl_next    = push_xl_reg;
        push_xr_next    = push_xr_reg;
        push_dn_next    = push_dn_reg;
        ret_next        = ret_reg;
        tog_r_next      = tog_r_reg;
        tog_c_next      = tog_c_reg;
        tog_vert_next   = tog_vert_reg;
        ovf_next        = ovf_reg;
        res_status_next = res_status_reg;
        res_pixel_next  = res_pixel_reg;
        img_we          = 1'b0;
        edge_v_we       = 1'b0;
        edge_h_we       = 1'b0;
        stk_we          = 1'b0;
        seed_we         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = llrf_pkg::ST_OK;
                res_pixel_next  = '0;
                ph_next         = 1'b0;
                state_next      = S_RESP;
                tog_r_next      = tr;
                tog_c_next      = tc;
                tog_vert_next   = tvert;
                case (func_reg)
                    llrf_pkg::FUNC_CLEAR:
                    begin
                        cur_next   = bg_reg;
                        cnt_next   = '0;
                        state_next = S_ICLR;
                    end
                    llrf_pkg::FUNC_LEVEL:
                    begin
                        prev_next     = cur_reg;
                        cur_next      = level_reg;
                        seed_cnt_next = '0;
                        line_next     = '0;
                        cnt_next      = '0;
                        state_next    = S_ECLR;
                    end
                    llrf_pkg::FUNC_FIRST, llrf_pkg::FUNC_NEXT:
                    begin
                        if (pt_out)
                        begin
                            res_status_next = llrf_pkg::ST_OUTSIDE;
                        end
                        else if (func_reg == llrf_pkg::FUNC_FIRST || line_reg == 2'd0)
                        begin
                            first_r_next = row_reg;
                            first_c_next = col_reg;
                            last_r_next  = row_reg;
                            last_c_next  = col_reg;
                            line_next    = 2'd1;
                        end
                        else if (!adj)
                        begin
                            res_status_next = llrf_pkg::ST_NOT_ADJ;
                        end
                        else
                        begin
                            if (line_reg == 2'd1)
                            begin
                                if (svalid)
                                begin
                                    seed_we       = 1'b1;
                                    seed_cnt_next = seed_cnt_reg + 1'b1;
                                end
                                line_next = 2'd2;
                            end
                            last_r_next = row_reg;
                            last_c_next = col_reg;
                            if (tvalid)
                            begin
                                state_next = S_TOG;
                            end
                        end
                    end
                    llrf_pkg::FUNC_END:
                    begin
                        line_next = '0;
                        if (line_reg != 2'd0 && closed_reg)
                        begin
                            if (!adj)
                            begin
                                res_status_next = llrf_pkg::ST_NOT_ADJ;
                            end
                            else if (tvalid)
                            begin
                                state_next = S_TOG;
                            end
                        end
                    end
                    llrf_pkg::FUNC_FILL:
                    begin
                        ovf_next   = 1'b0;
                        si_next    = '0;
                        state_next = S_SEED;
                    end
                    llrf_pkg::FUNC_READ:
                    begin
                        if (rd_out)
                        begin
                            res_status_next = llrf_pkg::ST_OUTSIDE;
                        end
                        else
                        begin
                            state_next = S_PRD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_ICLR:
            begin
                img_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(NPIX - 1))
                begin
                    state_next = S_RESP;
                end
            end
            S_ECLR:
            begin
                edge_v_we = 1'b1;
                edge_h_we = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == AW'(NPIX - 1))
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_RESP;
                end
            end
            S_TOG:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    edge_v_we  = tog_vert_reg;
                    edge_h_we  = !tog_vert_reg;
                    state_next = S_RESP;
                end
            end
            S_PRD:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    res_pixel_next = img_q;
                    state_next     = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEED:
            begin
                if (!ph_reg)
                begin
                    if (si_reg == seed_cnt_reg)
                    begin
                        seed_cnt_next   = '0;
                        sp_next         = '0;
                        res_status_next = ovf_reg ? llrf_pkg::ST_OVERFLOW : llrf_pkg::ST_OK;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    ph_next = 1'b0;
                    si_next = si_reg + 1'b1;
                    y_next  = sd_r;
                    x_next  = sd_c;
                    if (sd_r < dim_r && sd_c < dim_c)
                    begin
                        state_next = S_F0;
                    end
                end
            end
            S_F0:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (img_q == cur_reg)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        img_we     = 1'b1;
                        x1_next    = x_reg - 1;
                        state_next = S_L1;
                    end
                end
            end
            S_L1:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (can_h)
                    begin
                        img_we  = 1'b1;
                        x1_next = x1_reg - 1;
                    end
                    else
                    begin
                        x1_next    = x1_reg + 1;
                        x2_next    = x_reg + 1;
                        state_next = S_R1;
                    end
                end
            end
            S_R1:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (can_h)
                    begin
                        img_we  = 1'b1;
                        x2_next = x2_reg + 1;
                    end
                    else
                    begin
                        x2_next      = x2_reg - 1;
                        sp_next      = '0;
                        push_y_next  = y_reg;
                        push_xl_next = x1_reg;
                        push_xr_next = x2_reg - 1;
                        push_dn_next = 1'b1;
                        ret_next     = S_R1B;
                        state_next   = S_PUSH;
                    end
                end
            end
            S_R1B:
            begin
                push_y_next  = y_reg;
                push_xl_next = x1_reg;
                push_xr_next = x2_reg;
                push_dn_next = 1'b0;
                ret_next     = S_POP;
                state_next   = S_PUSH;
            end
            S_PUSH:
            begin
                ph_next    = 1'b0;
                state_next = ret_reg;
                if (push_tgt >= 0 && push_tgt < dim_r)
                begin
                    if (sp_reg == SPW'(STACK_DEPTH))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
            end
            S_POP:
            begin
                if (!ph_reg)
                begin
                    if (sp_reg == '0)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        sp_next = sp_m1;
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    ph_next    = 1'b0;
                    dn_next    = stk_q[SW-1];
                    y_next     = stk_q[SW-1] ? signed'(CW'(stk_q[YW-1:0])) + 1
                                             : signed'(CW'(stk_q[YW-1:0])) - 1;
                    x1_next    = signed'(CW'(stk_q[YW+XW-1:YW]));
                    x2_next    = signed'(CW'(stk_q[YW+2*XW-1:YW+XW]));
                    state_next = S_V;
                end
            end
            S_V:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (can_v)
                    begin
                        img_we     = 1'b1;
                        x_next     = x1_reg - 1;
                        state_next = S_HL;
                    end
                    else
                    begin
                        x_next     = x1_reg + 1;
                        state_next = S_EA;
                    end
                end
            end
            S_HL:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (can_h)
                    begin
                        img_we = 1'b1;
                        x_next = x_reg - 1;
                    end
                    else
                    begin
                        left_next = x_reg + 1;
                        x_next    = x1_reg;
                        if (x_reg + 1 < x1_reg)
                        begin
                            push_y_next  = y_reg;
                            push_xl_next = x_reg + 1;
                            push_xr_next = x1_reg - 1;
                            push_dn_next = !dn_reg;
                            ret_next     = S_MAIN;
                            state_next   = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_MAIN;
                        end
                    end
                end
            end
            S_EA:
            begin
                if (!ph_reg)
                begin
                    if (x_reg > x2_reg)
                    begin
                        left_next  = x_reg;
                        state_next = S_MAIN;
                    end
                    else
                    begin
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    ph_next = 1'b0;
                    if (hbit)
                    begin
                        x_next = x_reg + 1;
                    end
                    else
                    begin
                        left_next  = x_reg;
                        state_next = S_MAIN;
                    end
                end
            end
            S_MAIN:
            begin
                ph_next = 1'b0;
                if (x_reg <= x2_reg)
                begin
                    img_we     = 1'b1;
                    x_next     = x_reg + 1;
                    state_next = S_HR;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_HR:
            begin
                ph_next = !ph_reg;
                if (ph_reg)
                begin
                    if (can_h)
                    begin
                        img_we = 1'b1;
                        x_next = x_reg + 1;
                    end
                    else
                    begin
                        right_next = x_reg - 1;
                        if (x_reg - 1 > x2_reg)
                        begin
                            push_y_next  = y_reg;
                            push_xl_next = x2_reg + 1;
                            push_xr_next = x_reg - 1;
                            push_dn_next = !dn_reg;
                            ret_next     = S_HRB;
                            state_next   = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_HRB;
                        end
                    end
                end
            end
            S_HRB:
            begin
                push_y_next  = y_reg;
                push_xl_next = left_reg;
                push_xr_next = right_reg;
                push_dn_next = dn_reg;
                ret_next     = S_AFTER;
                state_next   = S_PUSH;
            end
            S_AFTER:
            begin
                ph_next    = 1'b0;
                x_next     = x_reg + 1;
                state_next = (x_reg < x2_reg) ? S_EA : S_MAIN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pixel_next  = out_pixel_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_RESP && (!out_valid_reg || m_tready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_pixel_next  = res_pixel_reg;
        end
    end

    assign s_tready  = state_reg == S_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'b0, out_pixel_reg, out_status_reg};
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_ECLR;
            ph_reg         <= 1'b0;
            init_reg       <= 1'b1;
            cnt_reg        <= '0;
            num_rows_reg   <= PW'(256);
            num_cols_reg   <= PW'(256);
            bg_reg         <= '0;
            func_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            level_reg      <= '0;
            closed_reg     <= 1'b0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            first_r_reg    <= '0;
            first_c_reg    <= '0;
            last_r_reg     <= '0;
            last_c_reg     <= '0;
            line_reg       <= '0;
            seed_cnt_reg   <= '0;
            si_reg         <= '0;
            sp_reg         <= '0;
            y_reg          <= '0;
            x_reg          <= '0;
            x1_reg         <= '0;
            x2_reg         <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            dn_reg         <= 1'b0;
            push_y_reg     <= '0;
            push_xl_reg    <= '0;
            push_xr_reg    <= '0;
            push_dn_reg    <= 1'b0;
            ret_reg        <= S_IDLE;
            tog_r_reg      <= '0;
            tog_c_reg      <= '0;
            tog_vert_reg   <= 1'b0;
            ovf_reg        <= 1'b0;
            res_status_reg <= '0;
            res_pixel_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_pixel_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            ph_reg         <= ph_next;
            init_reg       <= init_next;
            cnt_reg        <= cnt_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    llrf_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_data[PW-1:0];
                    llrf_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_data[PW-1:0];
                    llrf_pkg::CFG_BG_LEVEL: bg_reg <= cfg_data[LW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                func_reg   <= s_tuser;
                col_reg    <= s_tdata[8:0];
                row_reg    <= s_tdata[17:9];
                level_reg  <= s_tdata[33:18];
                closed_reg <= s_tdata[34];
            end
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            first_r_reg    <= first_r_next;
            first_c_reg    <= first_c_next;
            last_r_reg     <= last_r_next;
            last_c_reg     <= last_c_next;
            line_reg       <= line_next;
            seed_cnt_reg   <= seed_cnt_next;
            si_reg         <= si_next;
            sp_reg         <= sp_next;
            y_reg          <= y_next;
            x_reg          <= x_next;
            x1_reg         <= x1_next;
            x2_reg         <= x2_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            dn_reg         <= dn_next;
            push_y_reg     <= push_y_next;
            push_xl_reg    <= push_xl_next;
            push_xr_reg    <= push_xr_next;
            push_dn_reg    <= push_dn_next;
            ret_reg        <= ret_next;
            tog_r_reg      <= tog_r_next;
            tog_c_reg      <= tog_c_next;
            tog_vert_reg   <= tog_vert_next;
            ovf_reg        <= ovf_next;
            res_status_reg <= res_status_next;
            res_pixel_reg  <= res_pixel_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pixel_reg  <= out_pixel_next;
        end
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_seed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seed_cnt_reg <= SCNW'(SEED_DEPTH))
        else $error("seed count beyond depth");

    a_paint_inside: assert property (@(posedge clk) disable iff (!rst_n)
        img_we && state_reg != S_ICLR |-> in_img)
        else $error("paint outside image");

    a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RESP && (!out_valid_reg || m_tready) |=> out_valid_reg)
        else $error("result not loaded");

endmodule
